>>> rtl/centered_moving_average_core_assert.svh
// Assertion macros shared by the centered moving average RTL.
// Needs nothing else; include by bare file name where assertions are written.
`ifndef CENTERED_MOVING_AVERAGE_CORE_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CMA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CMA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cma_pkg.sv
// Package for the centered moving average core: default sizes, register
// width and reset value, and the sequencer state type. No dependencies.
package cma_pkg;

    localparam int DEF_MAX_HALF    = 16;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int CFG_BITS        = 5;
    localparam logic [CFG_BITS-1:0] WINDOW_HALF_RST = CFG_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_ADD,
        ST_FLUSH,
        ST_NEXT,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } cma_state_t;

endpackage

>>> rtl/centered_moving_average_core.sv
// Centered moving average core: sequencer, delay line memory and bit-serial divider.
// Depends on cma_pkg and on centered_moving_average_core_assert.svh.
//
// The core takes signed Q8.8 samples one transaction at a time, tlast marking
// the final sample of a record, and returns for each record position the mean
// over the samples from p-W to p+W that exist in the record, W being
// window_half capped at MAX_HALF; the quotient is truncated toward zero and
// the divisor is the true number of samples summed. The result for position p
// leaves once sample p+W has arrived, so output lags input by W samples; the
// final sample flushes every pending position, up to W+1 results, and the
// last of them carries tlast. Writing window_half clears the record. One item
// is handled at a time. Each result comes from the restoring divider, which
// retires one quotient bit per cycle over the SUM_BITS-bit window sum.
// A finished result sits in the output register, so an m_tready stall only
// holds the core once the next result is ready to leave.
module centered_moving_average_core #(
    parameter int MAX_HALF    = cma_pkg::DEF_MAX_HALF,
    parameter int SAMPLE_BITS = cma_pkg::DEF_SAMPLE_BITS,
    localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: window_half
    input  logic                          cfg_we,
    input  logic [cma_pkg::CFG_BITS-1:0]  cfg_wdata,
    // input samples
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [DATA_BITS-1:0]          s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
    input  logic                          s_tlast,   // last
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [DATA_BITS-1:0]          m_tdata,   // [SAMPLE_BITS-1:0] average, rest zero
    output logic                          m_tlast    // last_out
);

    localparam int DEPTH     = 2 * MAX_HALF + 1;
    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int SEEN_SAT  = 2 * MAX_HALF + 2;
    localparam int K_BITS    = $clog2(SEEN_SAT + 1);
    localparam int CW        = K_BITS + 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int W_BITS    = $clog2(MAX_HALF + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(DEPTH);
    localparam int STEP_BITS = $clog2(SUM_BITS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    cma_pkg::cma_state_t state_reg, state_next;

    logic [cma_pkg::CFG_BITS-1:0] window_half_reg;

    logic signed [SAMPLE_BITS-1:0] hist_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          hist_we;

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;

    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          last_reg, last_next;
    logic [K_BITS-1:0]             k_reg, k_next;
    logic [K_BITS-1:0]             seen_reg, seen_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic [W_BITS-1:0]             j_reg, j_next;

    // bit-serial divider: dividend shifts out at the top, quotient in at the bottom
    logic [SUM_BITS-1:0]  dvd_reg, dvd_next;
    logic [CNT_BITS-1:0]  rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] m_data_reg;
    logic                   m_last_reg;
    logic                   out_load;
    logic [SAMPLE_BITS-1:0] avg_val;
    logic                   fin_val;

    // ------------------------------------------------------------------
    // Window arithmetic
    // ------------------------------------------------------------------
    logic [W_BITS-1:0]   w_eff;
    logic [CW-1:0]       span;       // 2W+1
    logic [CW-1:0]       kj;         // samples before this one plus flush step
    logic [CW-1:0]       k1;
    logic [CW-1:0]       wr_ext;
    logic [PTR_BITS-1:0] drop_addr;
    logic [PTR_BITS-1:0] wr_inc;
    logic [PTR_BITS-1:0] rd_inc;
    logic                drop_now;
    logic                emit_now;
    logic                flush_done;
    logic [CNT_BITS:0]   rem_sh;
    logic                q_bit;
    logic [SAMPLE_BITS-1:0] q_low;

    // Saturate the half window at the delay line's reach.
    assign w_eff  = (int'(window_half_reg) > MAX_HALF) ? W_BITS'(MAX_HALF)
                                                       : W_BITS'(window_half_reg);
    assign span   = CW'({w_eff, 1'b0}) + CW'(1);
    assign kj     = CW'(k_reg) + CW'(j_reg);
    assign k1     = CW'(k_reg) + CW'(1);
    assign wr_ext = CW'(wr_ptr_reg);

    // Oldest sample of the full window, relative to the slot about to be written.
    assign drop_addr = (wr_ext >= span) ? PTR_BITS'(wr_ext - span)
                                        : PTR_BITS'(wr_ext + CW'(DEPTH) - span);
    assign wr_inc = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
    assign rd_inc = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);

    // Drop the leftmost sample once it falls outside the window; emit once the
    // centre position has all the right-hand samples it will ever get.
    assign drop_now   = (kj >= span);
    assign emit_now   = (kj >= CW'(w_eff));
    assign flush_done = (j_reg == w_eff);

    // One restoring division step.
    assign rem_sh = {rem_reg, dvd_reg[SUM_BITS-1]};
    assign q_bit  = (rem_sh >= (CNT_BITS + 1)'(cnt_reg));

    // Apply the sign to the quotient; only the low bits leave the core.
    assign q_low   = dvd_reg[SAMPLE_BITS-1:0];
    assign avg_val = neg_reg ? (~q_low + SAMPLE_BITS'(1)) : q_low;
    assign fin_val = last_reg && flush_done;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        x_next = x_reg;
        last_next = last_reg;
        k_next = k_reg;
        seen_next = seen_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        j_next = j_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        step_next = step_reg;
        hist_we = 1'b0;
        out_load = 1'b0;
        s_tready = 1'b0;

        case (state_reg)
            cma_pkg::ST_IDLE: begin
                s_tready = !cfg_we;
                if (s_tvalid && !cfg_we) begin
                    // Store the sample and aim the read port at the sample
                    // leaving the window; the read sees the slot's old value.
                    hist_we = 1'b1;
                    x_next = s_tdata[SAMPLE_BITS-1:0];
                    last_next = s_tlast;
                    k_next = seen_reg;
                    seen_next = (seen_reg == K_BITS'(SEEN_SAT)) ? seen_reg
                                                                : seen_reg + K_BITS'(1);
                    wr_ptr_next = wr_inc;
                    rd_ptr_next = drop_addr;
                    j_next = '0;
                    state_next = cma_pkg::ST_DROP;
                end
            end
            cma_pkg::ST_DROP: begin
                if (drop_now) begin
                    sum_next = sum_reg - SUM_BITS'(rd_data_reg);
                end
                state_next = cma_pkg::ST_ADD;
            end
            cma_pkg::ST_ADD: begin
                sum_next = sum_reg + SUM_BITS'(x_reg);
                cnt_next = CNT_BITS'((k1 < span) ? k1 : span);
                state_next = emit_now ? cma_pkg::ST_PREP : cma_pkg::ST_NEXT;
            end
            cma_pkg::ST_FLUSH: begin
                if (drop_now) begin
                    sum_next = sum_reg - SUM_BITS'(rd_data_reg);
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
                state_next = emit_now ? cma_pkg::ST_PREP : cma_pkg::ST_NEXT;
            end
            cma_pkg::ST_NEXT: begin
                if (!last_reg) begin
                    state_next = cma_pkg::ST_IDLE;
                end else if (flush_done) begin
                    // End of record: start the next one afresh.
                    seen_next = '0;
                    sum_next = '0;
                    wr_ptr_next = '0;
                    j_next = '0;
                    state_next = cma_pkg::ST_IDLE;
                end else begin
                    j_next = j_reg + W_BITS'(1);
                    rd_ptr_next = rd_inc;
                    state_next = cma_pkg::ST_FLUSH;
                end
            end
            cma_pkg::ST_PREP: begin
                neg_next = sum_reg[SUM_BITS-1];
                dvd_next = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
                rem_next = '0;
                step_next = STEP_BITS'(SUM_BITS - 1);
                state_next = cma_pkg::ST_DIV;
            end
            cma_pkg::ST_DIV: begin
                rem_next = q_bit ? CNT_BITS'(rem_sh - (CNT_BITS + 1)'(cnt_reg))
                                 : CNT_BITS'(rem_sh);
                dvd_next = {dvd_reg[SUM_BITS-2:0], q_bit};
                if (step_reg == '0) begin
                    state_next = cma_pkg::ST_OUT;
                end else begin
                    step_next = step_reg - STEP_BITS'(1);
                end
            end
            cma_pkg::ST_OUT: begin
                // Hold until the output register is free or being emptied.
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    state_next = cma_pkg::ST_NEXT;
                end
            end
            default: begin
                state_next = cma_pkg::ST_IDLE;
            end
        endcase

        // A window change drops the record in progress.
        if (cfg_we) begin
            seen_next = '0;
            sum_next = '0;
            wr_ptr_next = '0;
            j_next = '0;
            state_next = cma_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cma_pkg::ST_IDLE;
            window_half_reg <= cma_pkg::WINDOW_HALF_RST;
            seen_reg <= '0;
            sum_reg <= '0;
            wr_ptr_reg <= '0;
            j_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                window_half_reg <= cfg_wdata;
            end
            seen_reg <= seen_next;
            sum_reg <= sum_next;
            wr_ptr_reg <= wr_ptr_next;
            j_reg <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
        x_reg <= x_next;
        last_reg <= last_next;
        k_reg <= k_next;
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        step_reg <= step_next;
    end

    // ------------------------------------------------------------------
    // Delay line: one write port, one registered read port (read-first)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[wr_ptr_reg] <= s_tdata[SAMPLE_BITS-1:0];
        end
        rd_data_reg <= hist_mem[rd_ptr_next];
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= avg_val;
            m_last_reg <= fin_val;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_BITS'(m_data_reg);
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "centered_moving_average_core_assert.svh"

    `CMA_ASSERT_IMP(a_div_nonzero, aclk, aresetn, state_reg == cma_pkg::ST_DIV, cnt_reg != '0, "divider running with zero count")
    `CMA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")
    `CMA_ASSERT_IMP(a_flush_step, aclk, aresetn, state_reg == cma_pkg::ST_FLUSH, (j_reg != '0) && (j_reg <= w_eff), "flush step outside half window")

endmodule
